// File: rtl/core/lfdc_pkg.sv
// shared types and constants of the line follow drive controller
`default_nettype none
package lfdc_pkg;

   localparam int unsigned FRAME_WIDTH = 79;

   localparam logic [9:0]  MIN_VALID_CM  = 10'd3;
   localparam logic [9:0]  CLEAR_CM      = 10'd25;
   localparam logic [1:0]  NEAR_CONFIRM  = 2'd2;
   localparam logic [2:0]  CLEAR_CONFIRM = 3'd5;
   localparam logic [10:0] SPEED_LIMIT   = 11'd1600;
   localparam logic [9:0]  HELD_RESET    = 10'd999;
   localparam logic [3:0]  TAG_STOP      = 4'd1;

   typedef enum logic [1:0] {
      MODE_FOLLOW = 2'd0,
      MODE_STOP   = 2'd1,
      MODE_WAIT   = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      REG_PROP_GAIN     = 3'd0,
      REG_DERIV_GAIN    = 3'd1,
      REG_SMOOTH_ALPHA  = 3'd2,
      REG_DEAD_OFFSET   = 3'd3,
      REG_HEADING_LIMIT = 3'd4,
      REG_CRUISE_BASE   = 3'd5,
      REG_CROSSING_BASE = 3'd6,
      REG_NEAR_LIMIT    = 3'd7
   } reg_index_type;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_PROP     = 7'b0000010,
      ST_DERIV    = 7'b0000100,
      ST_FILT_NEW = 7'b0001000,
      ST_FILT_OLD = 7'b0010000,
      ST_HEAD     = 7'b0100000,
      ST_SPEED    = 7'b1000000
   } state_type;

endpackage
`default_nettype wire

// File: rtl/core/line_follow_drive_controller.sv
// pd line following drive controller with one shared multiplier
// path: a word goes straight to ST_SPEED when halted, with no line seen or on a first
// line tick; else the pd filter runs ST_PROP to ST_HEAD first, with four passes
// through the shared multiplier; words are taken one at a time, the next in the cycle
// after the result is loaded, while that result may still wait in the output register
// reset: synchronous, active high; control and csr regs to defaults, mode follow line
`default_nettype none
module line_follow_drive_controller (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_sample_new,
   input  wire logic [9:0]  req_range_cm,
   input  wire logic        req_line_seen,
   input  wire logic [7:0]  req_line_pos,
   input  wire logic        req_crossing_flag,
   input  wire logic        req_tag_seen,
   input  wire logic [3:0]  req_tag_code,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_drive_mode,
   output logic signed [11:0] rsp_left_speed,
   output logic signed [11:0] rsp_right_speed,
   output logic signed [11:0] rsp_steer_value,
   output logic             rsp_warn_lamp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import lfdc_pkg::*;

   // configuration registers
   logic [11:0] prop_gain_ff, deriv_gain_ff;
   logic [8:0]  smooth_alpha_ff;
   logic [10:0] dead_offset_ff, heading_limit_ff, cruise_base_ff, crossing_base_ff;
   logic [9:0]  near_limit_ff;
   logic [2:0]  csr_index;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff     <= 12'd768;
         deriv_gain_ff    <= 12'd282;
         smooth_alpha_ff  <= 9'd166;
         dead_offset_ff   <= 11'd48;
         heading_limit_ff <= 11'd1152;
         cruise_base_ff   <= 11'd960;
         crossing_base_ff <= 11'd720;
         near_limit_ff    <= 10'd20;
      end else if (csr_write) begin
         unique case (reg_index_type'(csr_index))
            REG_PROP_GAIN:     prop_gain_ff     <= csr_pwdata[11:0];
            REG_DERIV_GAIN:    deriv_gain_ff    <= csr_pwdata[11:0];
            REG_SMOOTH_ALPHA:  smooth_alpha_ff  <= csr_pwdata[8:0];
            REG_DEAD_OFFSET:   dead_offset_ff   <= csr_pwdata[10:0];
            REG_HEADING_LIMIT: heading_limit_ff <= csr_pwdata[10:0];
            REG_CRUISE_BASE:   cruise_base_ff   <= csr_pwdata[10:0];
            REG_CROSSING_BASE: crossing_base_ff <= csr_pwdata[10:0];
            REG_NEAR_LIMIT:    near_limit_ff    <= csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(csr_index))
         REG_PROP_GAIN:     csr_prdata = {20'd0, prop_gain_ff};
         REG_DERIV_GAIN:    csr_prdata = {20'd0, deriv_gain_ff};
         REG_SMOOTH_ALPHA:  csr_prdata = {23'd0, smooth_alpha_ff};
         REG_DEAD_OFFSET:   csr_prdata = {21'd0, dead_offset_ff};
         REG_HEADING_LIMIT: csr_prdata = {21'd0, heading_limit_ff};
         REG_CRUISE_BASE:   csr_prdata = {21'd0, cruise_base_ff};
         REG_CROSSING_BASE: csr_prdata = {21'd0, crossing_base_ff};
         REG_NEAR_LIMIT:    csr_prdata = {22'd0, near_limit_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   // control state
   state_type          state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic signed [9:0]  last_err_ff, last_err_in;
   logic signed [11:0] last_steer_ff, last_steer_in;
   logic               have_hist_ff, have_hist_in;
   logic [1:0]         near_ff, near_in;
   logic [2:0]         clear_ff, clear_in;
   logic [9:0]         held_ff, held_in;
   // per word working registers
   logic signed [9:0]  err_ff, err_in;
   logic signed [11:0] head_ff, head_in;
   logic               drive_ff, drive_in;
   logic               cross_ff, cross_in;
   logic signed [31:0] acc_ff, acc_in;
   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         out_mode_ff, out_mode_in;
   logic signed [11:0] out_left_ff, out_left_in;
   logic signed [11:0] out_right_ff, out_right_in;
   logic signed [11:0] out_steer_ff, out_steer_in;

   // shared multiplier
   logic signed [13:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [31:0] prod;
   logic [8:0]         alpha_eff;
   logic [8:0]         alpha_inv;
   logic signed [9:0]  err_diff;

   assign alpha_eff = (smooth_alpha_ff > 9'd256) ? 9'd256 : smooth_alpha_ff;
   assign alpha_inv = 9'd256 - alpha_eff;
   assign err_diff  = err_ff - last_err_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_PROP: begin
            mul_a = signed'({2'b00, prop_gain_ff});
            mul_b = {{8{err_ff[9]}}, err_ff};
         end
         ST_DERIV: begin
            mul_a = signed'({2'b00, deriv_gain_ff});
            mul_b = {{8{err_diff[9]}}, err_diff};
         end
         ST_FILT_NEW: begin
            // raw pd term, floor of the sum over 32
            mul_a = signed'({5'b00000, alpha_inv});
            mul_b = acc_ff[22:5];
         end
         ST_FILT_OLD: begin
            mul_a = signed'({5'b00000, alpha_eff});
            mul_b = {{6{last_steer_ff[11]}}, last_steer_ff};
         end
         default: ;
      endcase
   end

   assign prod = 32'(mul_a) * 32'(mul_b);

   // heading from the filter sum: floor over 256, dead offset added away from zero, clamp
   logic signed [19:0] filt_h;
   logic signed [21:0] dead_h;
   logic [10:0]        lim_eff;
   logic signed [21:0] lim_pos;
   logic signed [11:0] head_new;

   assign filt_h  = acc_ff[27:8];
   assign lim_eff = (heading_limit_ff > SPEED_LIMIT) ? SPEED_LIMIT : heading_limit_ff;
   assign lim_pos = signed'({11'd0, lim_eff});

   always_comb begin
      dead_h = {{2{filt_h[19]}}, filt_h};
      if (filt_h > 20'sd0) begin
         dead_h = dead_h + signed'({11'd0, dead_offset_ff});
      end else if (filt_h < 20'sd0) begin
         dead_h = dead_h - signed'({11'd0, dead_offset_ff});
      end
      if (dead_h > lim_pos) begin
         head_new = lim_pos[11:0];
      end else if (dead_h < -lim_pos) begin
         head_new = 12'(-lim_pos);
      end else begin
         head_new = dead_h[11:0];
      end
   end

   // wheel speeds from base and heading
   logic [10:0]        base_sel;
   logic signed [12:0] sum_left, sum_right;
   logic signed [12:0] spd_lim;
   logic signed [11:0] left_sat, right_sat;

   assign base_sel  = cross_ff ? crossing_base_ff : cruise_base_ff;
   assign spd_lim   = signed'({2'b00, SPEED_LIMIT});
   assign sum_left  = signed'({2'b00, base_sel}) + {head_ff[11], head_ff};
   assign sum_right = signed'({2'b00, base_sel}) - {head_ff[11], head_ff};

   always_comb begin
      if (sum_left > spd_lim) begin
         left_sat = spd_lim[11:0];
      end else if (sum_left < -spd_lim) begin
         left_sat = 12'(-spd_lim);
      end else begin
         left_sat = sum_left[11:0];
      end
      if (sum_right > spd_lim) begin
         right_sat = spd_lim[11:0];
      end else if (sum_right < -spd_lim) begin
         right_sat = 12'(-spd_lim);
      end else begin
         right_sat = sum_right[11:0];
      end
   end

   // distance and mode decisions for an incoming word
   logic              accept;
   logic [9:0]        held_new;
   logic [1:0]        near_new;
   logic [2:0]        clear_new;
   logic signed [9:0] err_new;

   assign accept  = req_valid && (state_ff == ST_IDLE);
   assign err_new = signed'(10'(FRAME_WIDTH)) - signed'({1'b0, req_line_pos, 1'b0});

   always_comb begin
      held_new = held_ff;
      near_new = near_ff;
      if (req_sample_new) begin
         held_new = req_range_cm;
         if (req_range_cm >= MIN_VALID_CM && req_range_cm <= near_limit_ff) begin
            near_new = (near_ff == 2'd3) ? near_ff : near_ff + 2'd1;
         end else begin
            near_new = 2'd0;
         end
      end
      if (held_new > CLEAR_CM || held_new < MIN_VALID_CM) begin
         clear_new = (clear_ff == 3'd7) ? clear_ff : clear_ff + 3'd1;
      end else begin
         clear_new = 3'd0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      last_err_in   = last_err_ff;
      last_steer_in = last_steer_ff;
      have_hist_in  = have_hist_ff;
      near_in       = near_ff;
      clear_in      = clear_ff;
      held_in       = held_ff;
      err_in        = err_ff;
      head_in       = head_ff;
      drive_in      = drive_ff;
      cross_in      = cross_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      out_mode_in   = out_mode_ff;
      out_left_in   = out_left_ff;
      out_right_in  = out_right_ff;
      out_steer_in  = out_steer_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               held_in  = held_new;
               near_in  = near_new;
               cross_in = req_crossing_flag;
               err_in   = err_new;
               head_in  = '0;
               drive_in = 1'b0;
               state_in = ST_SPEED;
               if (mode_ff == MODE_FOLLOW && near_new >= NEAR_CONFIRM) begin
                  mode_in       = MODE_WAIT;
                  near_in       = 2'd0;
                  clear_in      = 3'd0;
                  last_err_in   = '0;
                  last_steer_in = '0;
                  have_hist_in  = 1'b0;
               end else if (mode_ff == MODE_WAIT) begin
                  clear_in = clear_new;
                  if (clear_new >= CLEAR_CONFIRM) begin
                     mode_in       = MODE_FOLLOW;
                     near_in       = 2'd0;
                     clear_in      = 3'd0;
                     last_err_in   = '0;
                     last_steer_in = '0;
                     have_hist_in  = 1'b0;
                  end
               end else if (req_tag_seen && req_tag_code == TAG_STOP) begin
                  mode_in = MODE_STOP;
               end else if (mode_ff == MODE_FOLLOW) begin
                  if (!req_line_seen) begin
                     have_hist_in = 1'b0;
                  end else begin
                     drive_in = 1'b1;
                     if (have_hist_ff) begin
                        state_in = ST_PROP;
                     end else begin
                        // first line tick steers straight
                        last_err_in   = err_new;
                        last_steer_in = '0;
                        have_hist_in  = 1'b1;
                     end
                  end
               end
            end
         end
         ST_PROP: begin
            acc_in   = prod;
            state_in = ST_DERIV;
         end
         ST_DERIV: begin
            acc_in   = acc_ff + prod;
            state_in = ST_FILT_NEW;
         end
         ST_FILT_NEW: begin
            acc_in   = prod;
            state_in = ST_FILT_OLD;
         end
         ST_FILT_OLD: begin
            acc_in   = acc_ff + prod;
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            head_in       = head_new;
            last_err_in   = err_ff;
            last_steer_in = head_new;
            state_in      = ST_SPEED;
         end
         ST_SPEED: begin
            // wait here while the previous word still sits in the output register
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               out_mode_in  = mode_ff;
               out_left_in  = drive_ff ? left_sat : '0;
               out_right_in = drive_ff ? right_sat : '0;
               out_steer_in = drive_ff ? head_ff : '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= MODE_FOLLOW;
         last_err_ff   <= '0;
         last_steer_ff <= '0;
         have_hist_ff  <= 1'b0;
         near_ff       <= 2'd0;
         clear_ff      <= 3'd0;
         held_ff       <= HELD_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         last_err_ff   <= last_err_in;
         last_steer_ff <= last_steer_in;
         have_hist_ff  <= have_hist_in;
         near_ff       <= near_in;
         clear_ff      <= clear_in;
         held_ff       <= held_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff       <= err_in;
      head_ff      <= head_in;
      drive_ff     <= drive_in;
      cross_ff     <= cross_in;
      acc_ff       <= acc_in;
      out_mode_ff  <= out_mode_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
      out_steer_ff <= out_steer_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_mode  = out_mode_ff;
   assign rsp_left_speed  = out_left_ff;
   assign rsp_right_speed = out_right_ff;
   assign rsp_steer_value = out_steer_ff;
   assign rsp_warn_lamp   = (out_mode_ff == MODE_WAIT);

endmodule
`default_nettype wire
